// File: hw/rtl/pig_pkg.sv
// ----------------------------------------------------------------------------
// pig_pkg: primitive index generator shared definitions
// Command and mode codes, result kinds, beat types and the register map.
// ----------------------------------------------------------------------------
package pig_pkg;

  // Width of a vertex index (fixed by the result beat layout)
  localparam int INDEX_BITS = 16;

  // Most results one command can produce (a quad completes two triangles)
  localparam int MAX_RESULTS = 6;
  localparam int COUNT_BITS  = $clog2(MAX_RESULTS + 1);

  // Commands
  localparam logic [1:0] CMD_BEGIN  = 2'd0;
  localparam logic [1:0] CMD_VERTEX = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;
  localparam logic [1:0] CMD_RESET  = 2'd3;

  // Primitive modes
  localparam logic [3:0] MODE_POINTS     = 4'd0;
  localparam logic [3:0] MODE_LINES      = 4'd1;
  localparam logic [3:0] MODE_LINE_LOOP  = 4'd2;
  localparam logic [3:0] MODE_LINE_STRIP = 4'd3;
  localparam logic [3:0] MODE_TRIANGLES  = 4'd4;
  localparam logic [3:0] MODE_TRI_STRIP  = 4'd5;
  localparam logic [3:0] MODE_TRI_FAN    = 4'd6;
  localparam logic [3:0] MODE_QUADS      = 4'd7;
  localparam logic [3:0] MODE_POLYGON    = 4'd8;

  // Topology classes
  localparam logic [1:0] CLASS_POINT    = 2'd0;
  localparam logic [1:0] CLASS_LINE     = 2'd1;
  localparam logic [1:0] CLASS_TRIANGLE = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_INDEX = 2'd0;
  localparam logic [1:0] KIND_FLUSH = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Register map
  localparam int          PADDR_BITS       = 3;
  localparam logic [2:0]  ADDR_FLUSH_ENABLE = 3'd0;

  // Command beat
  typedef struct packed {
    logic [1:0] command;
    logic [3:0] prim_mode;
  } cmd_beat_t;

  // Result beat
  typedef struct packed {
    logic [INDEX_BITS-1:0] index_value;
    logic [1:0]            result_kind;
    logic                  last_of_run;
  } res_beat_t;

endpackage

// File: hw/rtl/primitive_index_generator_unit.sv
// ----------------------------------------------------------------------------
// primitive_index_generator_unit: primitive assembly index list builder
// Turns begin / vertex / end / reset commands into point, line or triangle
// index lists, with flush beats on topology change (when enabled) and error beats.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake            Payload
//  cmd       in   cmd_valid/cmd_stall  pig_pkg::cmd_beat_t (command, prim_mode)
//  res       out  res_valid/res_stall  pig_pkg::res_beat_t (index, kind, last)
//  cfg       in   APB psel/penable     flush_enable at byte address 0
//
//  A command is decoded in the cycle it is taken and its whole result list
//  (0 to 6 beats) is loaded into a shift buffer; the buffer sends one beat a
//  cycle while res_stall is low. A vertex of a triangle list gives 1 beat, a
//  triangle fan or strip vertex from the third on 3, a quad's fourth vertex 6.
//  The next command is taken in the cycle the last buffered beat leaves.
//  rst is synchronous; it empties the buffer and sets flush_enable to 1.
//  res_stall holds the buffer, and through it cmd_stall.
module primitive_index_generator_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  pig_pkg::cmd_beat_t                  cmd,
  output logic                                res_valid,
  input  logic                                res_stall,
  output pig_pkg::res_beat_t                  res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pig_pkg::PADDR_BITS-1:0]      paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam logic [pig_pkg::INDEX_BITS-1:0] IDX_MAX = '1;

  // Builder state
  logic                             flush_enable;
  logic [pig_pkg::INDEX_BITS-1:0]   vertex_counter, vertex_counter_next;
  logic [pig_pkg::INDEX_BITS-1:0]   primitive_start, primitive_start_next;
  logic                             inside_begin, inside_begin_next;
  logic [3:0]                       current_mode, current_mode_next;
  logic [1:0]                       topology_class, topology_class_next;
  logic                             topology_known, topology_known_next;

  // Result buffer
  pig_pkg::res_beat_t               rbuf [pig_pkg::MAX_RESULTS];
  logic [pig_pkg::COUNT_BITS-1:0]   count;

  // Decoded result list of the incoming command
  logic [pig_pkg::INDEX_BITS-1:0]   lst_idx [pig_pkg::MAX_RESULTS];
  logic [1:0]                       lst_kind;
  logic [pig_pkg::COUNT_BITS-1:0]   lst_cnt;

  logic                             accept, take;
  logic [pig_pkg::INDEX_BITS-1:0]   vi, vs, vn;
  logic [pig_pkg::INDEX_BITS-1:0]   vim1, vim2, vim3;
  logic [1:0]                       cls;

  // Handshake
  assign res_valid = (count != '0);
  assign res       = rbuf[0];
  assign take      = res_valid && !res_stall;
  assign cmd_stall = (count != '0) && !(take && (count == pig_pkg::COUNT_BITS'(1)));
  assign accept    = cmd_valid && !cmd_stall;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == pig_pkg::ADDR_FLUSH_ENABLE) ? {31'd0, flush_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready &&
                 paddr == pig_pkg::ADDR_FLUSH_ENABLE) begin
      flush_enable <= pwdata[0];
    end
  end

  // Running values for the vertex step
  assign vi   = vertex_counter;
  assign vs   = primitive_start;
  assign vn   = vi - vs;
  assign vim1 = vi - pig_pkg::INDEX_BITS'(1);
  assign vim2 = vi - pig_pkg::INDEX_BITS'(2);
  assign vim3 = vi - pig_pkg::INDEX_BITS'(3);
  assign cls  = (cmd.prim_mode == pig_pkg::MODE_POINTS) ? pig_pkg::CLASS_POINT :
                (cmd.prim_mode <= pig_pkg::MODE_LINE_STRIP) ? pig_pkg::CLASS_LINE :
                pig_pkg::CLASS_TRIANGLE;

  // Command decode: next state and result list
  always_comb begin
    vertex_counter_next  = vertex_counter;
    primitive_start_next = primitive_start;
    inside_begin_next    = inside_begin;
    current_mode_next    = current_mode;
    topology_class_next  = topology_class;
    topology_known_next  = topology_known;
    lst_kind             = pig_pkg::KIND_INDEX;
    lst_cnt              = '0;
    for (int j = 0; j < pig_pkg::MAX_RESULTS; j++) begin
      lst_idx[j] = '0;
    end

    case (cmd.command)
      pig_pkg::CMD_BEGIN: begin
        if (inside_begin || cmd.prim_mode > pig_pkg::MODE_POLYGON) begin
          lst_kind = pig_pkg::KIND_ERROR;
          lst_cnt  = pig_pkg::COUNT_BITS'(1);
        end else begin
          if (topology_known && cls != topology_class && flush_enable) begin
            lst_kind = pig_pkg::KIND_FLUSH;
            lst_cnt  = pig_pkg::COUNT_BITS'(1);
          end
          topology_class_next  = cls;
          topology_known_next  = 1'b1;
          current_mode_next    = cmd.prim_mode;
          inside_begin_next    = 1'b1;
          primitive_start_next = vertex_counter;
        end
      end
      pig_pkg::CMD_VERTEX: begin
        if (!inside_begin || vertex_counter == IDX_MAX) begin
          lst_kind = pig_pkg::KIND_ERROR;
          lst_cnt  = pig_pkg::COUNT_BITS'(1);
        end else begin
          vertex_counter_next = vi + pig_pkg::INDEX_BITS'(1);
          case (current_mode)
            pig_pkg::MODE_POINTS, pig_pkg::MODE_LINES, pig_pkg::MODE_TRIANGLES: begin
              lst_idx[0] = vi;
              lst_cnt    = pig_pkg::COUNT_BITS'(1);
            end
            pig_pkg::MODE_LINE_LOOP, pig_pkg::MODE_LINE_STRIP: begin
              if (vn != '0) begin
                lst_idx[0] = vim1;
                lst_idx[1] = vi;
                lst_cnt    = pig_pkg::COUNT_BITS'(2);
              end
            end
            pig_pkg::MODE_TRI_STRIP: begin
              if (vn >= pig_pkg::INDEX_BITS'(2)) begin
                // odd positions swap the first two to keep the winding
                lst_idx[0] = vn[0] ? vim1 : vim2;
                lst_idx[1] = vn[0] ? vim2 : vim1;
                lst_idx[2] = vi;
                lst_cnt    = pig_pkg::COUNT_BITS'(3);
              end
            end
            pig_pkg::MODE_TRI_FAN, pig_pkg::MODE_POLYGON: begin
              if (vn >= pig_pkg::INDEX_BITS'(2)) begin
                lst_idx[0] = vs;
                lst_idx[1] = vim1;
                lst_idx[2] = vi;
                lst_cnt    = pig_pkg::COUNT_BITS'(3);
              end
            end
            pig_pkg::MODE_QUADS: begin
              if (vn[1:0] == 2'b11) begin
                lst_idx[0] = vim3;
                lst_idx[1] = vim2;
                lst_idx[2] = vim1;
                lst_idx[3] = vim3;
                lst_idx[4] = vim1;
                lst_idx[5] = vi;
                lst_cnt    = pig_pkg::COUNT_BITS'(6);
              end
            end
            default: begin
            end
          endcase
        end
      end
      pig_pkg::CMD_END: begin
        if (!inside_begin) begin
          lst_kind = pig_pkg::KIND_ERROR;
          lst_cnt  = pig_pkg::COUNT_BITS'(1);
        end else begin
          inside_begin_next = 1'b0;
          // line loop closes last vertex back to first
          if (current_mode == pig_pkg::MODE_LINE_LOOP && vertex_counter != primitive_start) begin
            lst_idx[0] = vim1;
            lst_idx[1] = vs;
            lst_cnt    = pig_pkg::COUNT_BITS'(2);
          end
        end
      end
      default: begin
        if (inside_begin) begin
          lst_kind = pig_pkg::KIND_ERROR;
          lst_cnt  = pig_pkg::COUNT_BITS'(1);
        end else begin
          vertex_counter_next  = '0;
          primitive_start_next = '0;
          current_mode_next    = pig_pkg::MODE_POINTS;
          topology_class_next  = pig_pkg::CLASS_POINT;
          topology_known_next  = 1'b0;
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_counter  <= '0;
      primitive_start <= '0;
      inside_begin    <= 1'b0;
      current_mode    <= pig_pkg::MODE_POINTS;
      topology_class  <= pig_pkg::CLASS_POINT;
      topology_known  <= 1'b0;
    end else if (accept) begin
      vertex_counter  <= vertex_counter_next;
      primitive_start <= primitive_start_next;
      inside_begin    <= inside_begin_next;
      current_mode    <= current_mode_next;
      topology_class  <= topology_class_next;
      topology_known  <= topology_known_next;
    end
  end

  // Result buffer: load a whole list, shift one beat out per take
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= lst_cnt;
    end else if (take) begin
      count <= count - pig_pkg::COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < pig_pkg::MAX_RESULTS; j++) begin
        rbuf[j].index_value <= lst_idx[j];
        rbuf[j].result_kind <= lst_kind;
        rbuf[j].last_of_run <= (pig_pkg::COUNT_BITS'(j + 1) == lst_cnt);
      end
    end else if (take) begin
      for (int j = 0; j < pig_pkg::MAX_RESULTS - 1; j++) begin
        rbuf[j] <= rbuf[j + 1];
      end
    end
  end

  // Checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= pig_pkg::COUNT_BITS'(pig_pkg::MAX_RESULTS))
    else $error("result buffer count out of range");

  a_last_matches_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.last_of_run == (count == pig_pkg::COUNT_BITS'(1))))
    else $error("last_of_run does not mark the final buffered beat");

  a_counter_saturates: assert property (@(posedge clk) disable iff (rst)
    (vertex_counter == IDX_MAX && !(accept && cmd.command == pig_pkg::CMD_RESET))
    |=> vertex_counter == IDX_MAX)
    else $error("vertex counter left saturation without a reset");

  a_nested_begin_ignored: assert property (@(posedge clk) disable iff (rst)
    (accept && inside_begin && cmd.command == pig_pkg::CMD_BEGIN)
    |=> (inside_begin && $stable(primitive_start) && $stable(current_mode)))
    else $error("begin inside begin changed the builder state");

endmodule
